// File: hdl/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg
// Shared types and constants for the set-associative cache model with FIFO
// replacement.
// ----------------------------------------------------------------------------
`default_nettype none

package scf_pkg;

  // Field widths fixed by the request format
  localparam int unsigned ADDR_FIELD_W = 48;
  localparam int unsigned TOTAL_W      = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

  localparam logic [4:0] OFFSET_BITS_RST = 5'd6;
  localparam logic [3:0] INDEX_BITS_RST  = 4'd0;
  localparam logic [4:0] WAYS_IN_USE_RST = 5'd1;

  // Access kind
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [ADDR_FIELD_W-1:0] address;
  } scf_in_t;

  typedef struct packed {
    logic               hit;
    logic               mem_read;
    logic               mem_write;
    logic [TOTAL_W-1:0] read_total;
    logic [TOTAL_W-1:0] write_total;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
  } scf_out_t;

  // Outcome of one lookup, handed to the statistics counters
  typedef struct packed {
    logic hit;
    logic is_write;
  } scf_evt_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } scf_state_t;

endpackage

`default_nettype wire

// File: hdl/scf_tag_store.sv
// ----------------------------------------------------------------------------
// scf_tag_store
// Tag memory: one row per set, one tag per way. Whole-row synchronous read,
// single-way write.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_tag_store #(
  parameter int unsigned NROWS = 1024,
  parameter int unsigned SET_W = 10,
  parameter int unsigned WAYS  = 16,
  parameter int unsigned WAY_W = 4,
  parameter int unsigned TAG_W = 48
) (
  input  wire logic                            clk,
  input  wire logic                            rd_en,
  input  wire logic [SET_W-1:0]                rd_set,
  output logic      [WAYS-1:0][TAG_W-1:0]      rd_tags,
  input  wire logic                            wr_en,
  input  wire logic [SET_W-1:0]                wr_set,
  input  wire logic [WAY_W-1:0]                wr_way,
  input  wire logic [TAG_W-1:0]                wr_tag
);

  logic [TAG_W-1:0] mem [NROWS][WAYS];
  logic [WAYS-1:0][TAG_W-1:0] rd_tags_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_set][wr_way] <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      for (int w = 0; w < WAYS; w++) begin
        rd_tags_r[w] <= mem[rd_set][w];
      end
    end
  end

  assign rd_tags = rd_tags_r;

endmodule

`default_nettype wire

// File: hdl/scf_meta_store.sv
// ----------------------------------------------------------------------------
// scf_meta_store
// Per-set state memory: way valid bits and FIFO pointer, one row per set.
// Synchronous read, whole-row write.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_meta_store #(
  parameter int unsigned NROWS = 1024,
  parameter int unsigned SET_W = 10,
  parameter int unsigned WAYS  = 16,
  parameter int unsigned WAY_W = 4
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [SET_W-1:0] rd_set,
  output logic      [WAYS-1:0]  rd_valid,
  output logic      [WAY_W-1:0] rd_ptr,
  input  wire logic             wr_en,
  input  wire logic [SET_W-1:0] wr_set,
  input  wire logic [WAYS-1:0]  wr_valid,
  input  wire logic [WAY_W-1:0] wr_ptr
);

  logic [WAY_W+WAYS-1:0] mem [NROWS];
  logic [WAY_W+WAYS-1:0] rd_row_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_set] <= {wr_ptr, wr_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= mem[rd_set];
    end
  end

  assign rd_valid = rd_row_r[WAYS-1:0];
  assign rd_ptr   = rd_row_r[WAY_W+WAYS-1:WAYS];

endmodule

`default_nettype wire

// File: hdl/scf_hit_check.sv
// ----------------------------------------------------------------------------
// scf_hit_check
// Compares the request tag against the ways in use of one set row and picks
// the FIFO victim for a miss.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_hit_check #(
  parameter int unsigned WAYS  = 16,
  parameter int unsigned WAY_W = 4,
  parameter int unsigned CNT_W = 5,
  parameter int unsigned TAG_W = 48
) (
  input  wire logic [WAYS-1:0][TAG_W-1:0] tags,
  input  wire logic [WAYS-1:0]            valid,
  input  wire logic [WAY_W-1:0]           ptr,
  input  wire logic [TAG_W-1:0]           tag,
  input  wire logic [CNT_W-1:0]           ways,
  output logic                            hit,
  output logic      [WAY_W-1:0]           victim,
  output logic      [WAY_W-1:0]           ptr_nxt,
  output logic      [WAYS-1:0]            valid_nxt
);

  logic [WAYS-1:0]  match;
  logic [CNT_W-1:0] victim_ext;
  logic [CNT_W-1:0] next_ext;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = (w < int'(ways)) && valid[w] && (tags[w] == tag);
    end
  end

  assign hit = |match;

  // A pointer left beyond the way count (ways lowered) falls back to way 0
  always_comb begin
    victim_ext = CNT_W'(ptr);
    if (victim_ext >= ways) begin
      victim_ext = '0;
    end
    next_ext = victim_ext + CNT_W'(1);
    if (next_ext >= ways) begin
      next_ext = '0;
    end
  end

  assign victim    = WAY_W'(victim_ext);
  assign ptr_nxt   = WAY_W'(next_ext);
  assign valid_nxt = valid | (WAYS'(1) << victim);

endmodule

`default_nettype wire

// File: hdl/scf_counters.sv
// ----------------------------------------------------------------------------
// scf_counters
// Saturating request statistics: memory reads, memory writes, hits, misses.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_counters
  import scf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               upd,
  input  wire scf_evt_t           evt,
  output logic      [TOTAL_W-1:0] read_total,
  output logic      [TOTAL_W-1:0] write_total,
  output logic      [TOTAL_W-1:0] hit_total,
  output logic      [TOTAL_W-1:0] miss_total
);

  logic [TOTAL_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [TOTAL_W-1:0] wr_cnt_r, wr_cnt_nxt;
  logic [TOTAL_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [TOTAL_W-1:0] miss_cnt_r, miss_cnt_nxt;

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] c);
    return (c == '1) ? c : c + TOTAL_W'(1);
  endfunction

  always_comb begin
    rd_cnt_nxt   = rd_cnt_r;
    wr_cnt_nxt   = wr_cnt_r;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (upd) begin
      if (evt.hit) begin
        hit_cnt_nxt = sat_inc(hit_cnt_r);
      end else begin
        miss_cnt_nxt = sat_inc(miss_cnt_r);
        rd_cnt_nxt   = sat_inc(rd_cnt_r);
      end
      if (evt.is_write) begin
        wr_cnt_nxt = sat_inc(wr_cnt_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r   <= '0;
      wr_cnt_r   <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else begin
      rd_cnt_r   <= rd_cnt_nxt;
      wr_cnt_r   <= wr_cnt_nxt;
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
    end
  end

  assign read_total  = rd_cnt_r;
  assign write_total = wr_cnt_r;
  assign hit_total   = hit_cnt_r;
  assign miss_total  = miss_cnt_r;

endmodule

`default_nettype wire

// File: hdl/set_associative_cache_fifo_top.sv
// ----------------------------------------------------------------------------
// set_associative_cache_fifo_top
// Tag-only set-associative cache model with FIFO replacement, write-allocate
// and write-through, plus saturating hit/miss/read/write statistics.
// ----------------------------------------------------------------------------
// Usage: a request (kind, address) is taken on a rising edge with start high
// and busy low. On that edge the set row is read from the tag and state
// memories (registered read); then, in the lookup state, the tags are
// compared and, on a miss, the victim way and FIFO pointer are written back.
// busy is high in the lookup state, so no new request is taken until the
// current one has been looked up. The result is registered from the lookup
// state: it appears on out_payload with out_valid high for exactly one
// cycle; there is no back-pressure, so the receiver must take it then. After
// reset the block sweeps the state memory to clear all valid bits and FIFO
// pointers, one set per cycle, over all 2^floor(log2(MAX_SETS)) sets (1024 at
// the default size), with busy held high. Configuration writes on cfg_we are
// taken at any time but must only be issued while no request is in flight; a
// change does not flush the cache. index_bits is limited to the sets present,
// ways_in_use is clamped to 1..MAX_WAYS, and address bits above ADDRESS_WIDTH
// are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module set_associative_cache_fifo_top
  import scf_pkg::*;
#(
  parameter int unsigned MAX_SETS      = 1024,
  parameter int unsigned MAX_WAYS      = 16,
  parameter int unsigned ADDRESS_WIDTH = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire scf_in_t               in_payload,
  // result channel
  output logic                       out_valid,
  output scf_out_t                   out_payload,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Largest k with 2^k sets within MAX_SETS
  localparam int unsigned LIM   = $clog2(MAX_SETS + 1) - 1;
  localparam int unsigned NROWS = 1 << LIM;
  localparam int unsigned SET_W = (LIM > 0) ? LIM : 1;
  localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_WAYS + 1);
  localparam int unsigned TAG_W = ADDRESS_WIDTH;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [4:0] cfg_offset_r;
  logic [3:0] cfg_idx_bits_r;
  logic [4:0] cfg_ways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_offset_r   <= OFFSET_BITS_RST;
      cfg_idx_bits_r <= INDEX_BITS_RST;
      cfg_ways_r     <= WAYS_IN_USE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_BITS: cfg_offset_r   <= cfg_wdata;
        REG_INDEX_BITS:  cfg_idx_bits_r <= cfg_wdata[3:0];
        REG_WAYS_IN_USE: cfg_ways_r     <= cfg_wdata;
        default: ; // unmapped index: ignored
      endcase
    end
  end

  // Effective index width and way count after clamping
  logic [3:0]       idx_bits_eff;
  logic [CNT_W-1:0] ways_eff;

  always_comb begin
    idx_bits_eff = cfg_idx_bits_r;
    if (32'(cfg_idx_bits_r) > LIM) begin
      idx_bits_eff = 4'(LIM);
    end
    if (cfg_ways_r == '0) begin
      ways_eff = CNT_W'(1);
    end else if (32'(cfg_ways_r) > MAX_WAYS) begin
      ways_eff = CNT_W'(MAX_WAYS);
    end else begin
      ways_eff = CNT_W'(cfg_ways_r);
    end
  end

  // --------------------------------------------------------------------------
  // Address split: offset | set index | tag
  // --------------------------------------------------------------------------
  logic [TAG_W-1:0] addr_eff;
  logic [SET_W-1:0] set_mask;
  logic [SET_W-1:0] set_c;
  logic [TAG_W-1:0] tag_c;
  logic [5:0]       tag_shift;

  assign addr_eff  = TAG_W'(in_payload.address);
  assign set_mask  = ~({SET_W{1'b1}} << idx_bits_eff);
  assign set_c     = SET_W'(addr_eff >> cfg_offset_r) & set_mask;
  assign tag_shift = 6'(cfg_offset_r) + 6'(idx_bits_eff);
  assign tag_c     = addr_eff >> tag_shift;

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  scf_state_t state_r, state_nxt;
  logic       accept;
  logic       lookup;
  logic       clearing;
  logic [SET_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic       clr_last;

  assign accept   = start && !busy;
  assign clr_last = (clr_cnt_r == SET_W'(NROWS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (start) state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    lookup   = 1'b0;
    clearing = 1'b0;
    case (state_r)
      ST_CLEAR:  clearing = 1'b1;
      ST_IDLE:   busy     = 1'b0;
      ST_LOOKUP: lookup   = 1'b1;
      default:   busy     = 1'b1;
    endcase
  end

  assign clr_cnt_nxt = clearing ? clr_cnt_r + SET_W'(1) : clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Request held for the lookup cycle
  logic             kind_r;
  logic [SET_W-1:0] set_r;
  logic [TAG_W-1:0] tag_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_payload.kind;
      set_r  <= set_c;
      tag_r  <= tag_c;
    end
  end

  // --------------------------------------------------------------------------
  // Memories and compare
  // --------------------------------------------------------------------------
  logic [MAX_WAYS-1:0][TAG_W-1:0] row_tags;
  logic [MAX_WAYS-1:0]            row_valid;
  logic [WAY_W-1:0]               row_ptr;
  logic                           hit;
  logic [WAY_W-1:0]               victim;
  logic [WAY_W-1:0]               ptr_nxt;
  logic [MAX_WAYS-1:0]            valid_nxt;
  logic                           fill;

  // A miss installs the tag; busy holds off the next request during the lookup,
  // so the write-back lands before the next row read.
  assign fill = lookup && !hit;

  scf_tag_store #(
    .NROWS (NROWS),
    .SET_W (SET_W),
    .WAYS  (MAX_WAYS),
    .WAY_W (WAY_W),
    .TAG_W (TAG_W)
  ) u_tags (
    .clk     (clk),
    .rd_en   (accept),
    .rd_set  (set_c),
    .rd_tags (row_tags),
    .wr_en   (fill),
    .wr_set  (set_r),
    .wr_way  (victim),
    .wr_tag  (tag_r)
  );

  scf_meta_store #(
    .NROWS (NROWS),
    .SET_W (SET_W),
    .WAYS  (MAX_WAYS),
    .WAY_W (WAY_W)
  ) u_meta (
    .clk      (clk),
    .rd_en    (accept),
    .rd_set   (set_c),
    .rd_valid (row_valid),
    .rd_ptr   (row_ptr),
    .wr_en    (fill || clearing),
    .wr_set   (clearing ? clr_cnt_r : set_r),
    .wr_valid (clearing ? '0 : valid_nxt),
    .wr_ptr   (clearing ? '0 : ptr_nxt)
  );

  scf_hit_check #(
    .WAYS  (MAX_WAYS),
    .WAY_W (WAY_W),
    .CNT_W (CNT_W),
    .TAG_W (TAG_W)
  ) u_check (
    .tags      (row_tags),
    .valid     (row_valid),
    .ptr       (row_ptr),
    .tag       (tag_r),
    .ways      (ways_eff),
    .hit       (hit),
    .victim    (victim),
    .ptr_nxt   (ptr_nxt),
    .valid_nxt (valid_nxt)
  );

  // --------------------------------------------------------------------------
  // Statistics and result register
  // --------------------------------------------------------------------------
  scf_evt_t evt;

  assign evt.hit      = hit;
  assign evt.is_write = (kind_r == KIND_WRITE);

  logic [TOTAL_W-1:0] read_total;
  logic [TOTAL_W-1:0] write_total;
  logic [TOTAL_W-1:0] hit_total;
  logic [TOTAL_W-1:0] miss_total;

  scf_counters u_cnt (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (lookup),
    .evt         (evt),
    .read_total  (read_total),
    .write_total (write_total),
    .hit_total   (hit_total),
    .miss_total  (miss_total)
  );

  logic out_valid_r;
  logic hit_r;
  logic mem_wr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= lookup;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup) begin
      hit_r    <= hit;
      mem_wr_r <= evt.is_write;
    end
  end

  // Counters only move in the lookup cycle, so they hold through the strobe
  assign out_valid               = out_valid_r;
  assign out_payload.hit         = hit_r;
  assign out_payload.mem_read    = !hit_r;
  assign out_payload.mem_write   = mem_wr_r;
  assign out_payload.read_total  = read_total;
  assign out_payload.write_total = write_total;
  assign out_payload.hit_total   = hit_total;
  assign out_payload.miss_total  = miss_total;

endmodule

`default_nettype wire

// File: hdl/scf_checker.sv
// ----------------------------------------------------------------------------
// scf_checker
// Port-level checks on request/result timing and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_checker
  import scf_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     out_valid,
  input wire scf_out_t out_payload
);

  // Every accepted request is followed by its result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 out_valid)
    else $error("result not delivered two cycles after request");

  // Results only follow requests
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a request");

  // Strobe is a single-cycle pulse
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A miss always reads memory and has been counted
  a_miss_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload.hit |->
      out_payload.mem_read && out_payload.read_total != '0 &&
      out_payload.miss_total != '0)
    else $error("miss not reflected in counters");

  // A hit is counted and causes no memory read
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.hit |->
      !out_payload.mem_read && out_payload.hit_total != '0)
    else $error("hit not reflected in counters");

endmodule

bind set_associative_cache_fifo_top scf_checker u_scf_checker (.*);

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FIFO-replacement tag cache. A model cache
// with its own tag, valid and pointer arrays tracks every request and checks
// each result field. The stimulus is a short directed list followed by random
// phases under changing geometry.
// ----------------------------------------------------------------------------
module tb_top;
  import scf_pkg::*;

  localparam int unsigned NSETS        = 1024;
  localparam int unsigned NWAYS        = 16;
  localparam int unsigned IDX_CAP      = $clog2(NSETS);   // widest usable set index
  localparam int unsigned STALL_LIMIT  = 5000;            // covers the clearing sweep
  localparam int unsigned DRAIN_SETTLE = 4;
  localparam int unsigned RAND_PHASES  = 12;
  localparam int unsigned PHASE_REQS   = 45;
  localparam int unsigned REPORT_MAX   = 10;
  // index 3 maps to no register; a write there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic [1:0] {
    STEP_REQ,
    STEP_CFG,
    STEP_DRAIN
  } step_kind_t;

  typedef struct {
    step_kind_t            what;
    scf_in_t               req;
    logic [CFG_IDX_W-1:0]  reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    int unsigned           gap;
  } plan_step_t;

  // --------------------------------------------------------------------------
  // Clock and DUT hookup
  // --------------------------------------------------------------------------
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  start      = 1'b0;
  logic                  busy;
  scf_in_t               in_payload = '0;
  logic                  out_valid;
  scf_out_t              out_payload;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  set_associative_cache_fifo_top #(
    .MAX_SETS      (NSETS),
    .MAX_WAYS      (NWAYS),
    .ADDRESS_WIDTH (ADDR_FIELD_W)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_payload (out_payload),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Model cache: tags, per-way valid bits, per-set FIFO pointer, totals
  // --------------------------------------------------------------------------
  logic [ADDR_FIELD_W-1:0] line_tag   [NSETS*NWAYS];
  bit                      line_valid [NSETS*NWAYS];
  bit   [3:0]              fifo_next  [NSETS];
  bit   [TOTAL_W-1:0]      n_reads, n_writes, n_hits, n_misses;
  bit   [4:0]              geo_off  = OFFSET_BITS_RST;
  bit   [3:0]              geo_ib   = INDEX_BITS_RST;
  bit   [4:0]              geo_ways = WAYS_IN_USE_RST;

  function automatic bit [TOTAL_W-1:0] sat_inc(bit [TOTAL_W-1:0] c);
    return (&c) ? c : c + TOTAL_W'(1);
  endfunction

  // Look the request up, fill on a miss, bump the totals; returns the outcome
  function automatic scf_out_t cache_lookup_fill(scf_in_t req);
    int unsigned             ib, nways, set_no, base, victim, w;
    logic [ADDR_FIELD_W-1:0] tag;
    logic                    found;
    scf_out_t                res;
    ib     = (geo_ib > IDX_CAP) ? IDX_CAP : 32'(geo_ib);
    nways  = (geo_ways == 0) ? 1 : ((geo_ways > NWAYS) ? NWAYS : 32'(geo_ways));
    set_no = 32'((req.address >> geo_off) & ((48'd1 << ib) - 48'd1));
    tag    = req.address >> (geo_off + ib);
    base   = set_no * NWAYS;
    found  = 1'b0;
    for (w = 0; w < nways; w++) begin
      if (!found && line_valid[base+w] && line_tag[base+w] == tag) found = 1'b1;
    end
    if (found) begin
      n_hits = sat_inc(n_hits);
      if (req.kind == KIND_WRITE) n_writes = sat_inc(n_writes);
    end else begin
      // a pointer left beyond the way count (ways lowered) falls back to way 0
      victim = 32'(fifo_next[set_no]);
      if (victim >= nways) victim = 0;
      line_tag[base+victim]   = tag;
      line_valid[base+victim] = 1'b1;
      victim++;
      if (victim >= nways) victim = 0;
      fifo_next[set_no] = victim[3:0];
      n_misses = sat_inc(n_misses);
      n_reads  = sat_inc(n_reads);
      if (req.kind == KIND_WRITE) n_writes = sat_inc(n_writes);
    end
    res.hit         = found;
    res.mem_read    = !found;
    res.mem_write   = (req.kind == KIND_WRITE);
    res.read_total  = n_reads;
    res.write_total = n_writes;
    res.hit_total   = n_hits;
    res.miss_total  = n_misses;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request plan and bookkeeping shared by driver and monitor
  // --------------------------------------------------------------------------
  plan_step_t  access_plan_q[$];
  scf_out_t    outcome_q[$];
  int unsigned offered_cnt    = 0;   // requests put on the bus
  int unsigned taken_cnt      = 0;   // requests accepted by the block
  int unsigned hold_left      = 0;
  int unsigned cur_gap        = 0;
  int unsigned idle_cycles    = 0;
  int unsigned outcome_errors = 0;
  bit          quiet_run      = 1'b0;

  // geometry as the plan builder sees it, already clamped
  int unsigned plan_off, plan_ib, plan_ways;

  function automatic logic [ADDR_FIELD_W-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_FIELD_W-1:0];
  endfunction

  task automatic plan_req(logic kind, logic [ADDR_FIELD_W-1:0] addr);
    plan_step_t s;
    s.what        = STEP_REQ;
    s.req.kind    = kind;
    s.req.address = addr;
    s.reg_sel     = '0;
    s.reg_val     = '0;
    s.gap         = quiet_run ? 0 : $urandom_range(0, 6);
    access_plan_q.push_back(s);
  endtask

  task automatic plan_cfg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
    plan_step_t s;
    s.what    = STEP_CFG;
    s.req     = '0;
    s.reg_sel = sel;
    s.reg_val = val;
    s.gap     = 0;
    access_plan_q.push_back(s);
  endtask

  // hold further requests until every outstanding result is back
  task automatic plan_drain();
    plan_step_t s;
    s.what    = STEP_DRAIN;
    s.req     = '0;
    s.reg_sel = '0;
    s.reg_val = '0;
    s.gap     = 0;
    access_plan_q.push_back(s);
  endtask

  // idle the block, then rewrite all three geometry registers
  task automatic plan_geometry(logic [4:0] off, logic [4:0] ib, logic [4:0] ways);
    plan_drain();
    plan_cfg(REG_OFFSET_BITS, off);
    plan_cfg(REG_INDEX_BITS, ib);
    plan_cfg(REG_WAYS_IN_USE, ways);
    plan_off  = 32'(off);
    plan_ib   = (ib[3:0] > IDX_CAP) ? IDX_CAP : 32'(ib[3:0]);
    plan_ways = (ways == 0) ? 1 : ((ways > NWAYS) ? NWAYS : 32'(ways));
  endtask

  task automatic note_mismatch(string why, scf_out_t want, scf_out_t got);
    outcome_errors++;
    if (outcome_errors <= REPORT_MAX) begin
      $display("[%0t] %s", $time, why);
      $display("  want hit=%b rd=%b wr=%b reads=%0d writes=%0d hits=%0d misses=%0d",
               want.hit, want.mem_read, want.mem_write, want.read_total,
               want.write_total, want.hit_total, want.miss_total);
      $display("  got  hit=%b rd=%b wr=%b reads=%0d writes=%0d hits=%0d misses=%0d",
               got.hit, got.mem_read, got.mem_write, got.read_total,
               got.write_total, got.hit_total, got.miss_total);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: works through the plan on the falling edge. A request stays up
  // until the monitor has seen it taken; its gap then idles the bus.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    plan_step_t            step;
    logic                  start_nx, we_nx;
    scf_in_t               req_nx;
    logic [CFG_IDX_W-1:0]  idx_nx;
    logic [CFG_DATA_W-1:0] val_nx;
    start_nx = start;
    we_nx    = 1'b0;
    req_nx   = in_payload;
    idx_nx   = cfg_index;
    val_nx   = cfg_wdata;
    if (rst_n) begin
      if (start && taken_cnt == offered_cnt) begin
        // last request went in at the previous edge
        start_nx  = 1'b0;
        hold_left = cur_gap;
      end
      if (start && taken_cnt != offered_cnt) begin
        // still waiting for busy to drop: keep the request as it is
      end else if (hold_left != 0) begin
        hold_left--;
      end else if (access_plan_q.size() != 0) begin
        case (access_plan_q[0].what)
          STEP_REQ: begin
            step     = access_plan_q.pop_front();
            req_nx   = step.req;
            start_nx = 1'b1;
            cur_gap  = step.gap;
            offered_cnt++;
          end
          STEP_CFG: begin
            step   = access_plan_q.pop_front();
            we_nx  = 1'b1;
            idx_nx = step.reg_sel;
            val_nx = step.reg_val;
          end
          default: begin
            if (outcome_q.size() == 0) begin
              step      = access_plan_q.pop_front();
              hold_left = DRAIN_SETTLE;
            end
          end
        endcase
      end
    end
    start      <= start_nx;
    in_payload <= req_nx;
    cfg_we     <= we_nx;
    cfg_index  <= idx_nx;
    cfg_wdata  <= val_nx;
  end

  // --------------------------------------------------------------------------
  // Monitor: on the rising edge, check any result against the oldest outcome,
  // mirror register writes, and run accepted requests through the model.
  // Results are checked before new requests are queued, as the result on the
  // bus always belongs to an earlier request.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    scf_out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (outcome_q.size() == 0) begin
          note_mismatch("result with no request outstanding", '0, out_payload);
        end else begin
          want = outcome_q.pop_front();
          if (want.hit !== out_payload.hit || want.mem_read !== out_payload.mem_read ||
              want.mem_write !== out_payload.mem_write ||
              want.read_total !== out_payload.read_total ||
              want.write_total !== out_payload.write_total ||
              want.hit_total !== out_payload.hit_total ||
              want.miss_total !== out_payload.miss_total)
            note_mismatch("result field mismatch", want, out_payload);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_OFFSET_BITS: geo_off  = cfg_wdata;
          REG_INDEX_BITS:  geo_ib   = cfg_wdata[3:0];
          REG_WAYS_IN_USE: geo_ways = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        outcome_q.push_back(cache_lookup_fill(in_payload));
        taken_cnt++;
      end
      // watchdog: any handshake or register write counts as progress
      if ((start && !busy) || out_valid || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus plan, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    logic [ADDR_FIELD_W-1:0] addr;
    logic [ADDR_FIELD_W-1:0] set_pool [4];
    logic [ADDR_FIELD_W-1:0] tag_pool [40];
    logic [4:0]              off_w, ib_w, ways_w;
    int unsigned             nsets, ntags;

    plan_off  = OFFSET_BITS_RST;
    plan_ib   = INDEX_BITS_RST;
    plan_ways = WAYS_IN_USE_RST;

    // Reset geometry: 64-byte lines, one set, direct-mapped
    plan_req(KIND_READ,  48'h0);               // cold miss
    plan_req(KIND_READ,  48'h3F);              // same line: hit
    plan_req(KIND_WRITE, 48'h0);               // write hit, write-through
    plan_req(KIND_WRITE, 48'hFFFF_FFFF_FFFF);  // write miss, allocates over tag 0
    plan_req(KIND_READ,  48'hFFFF_FFFF_FFFF);  // hit
    plan_req(KIND_READ,  48'h0);               // evicted earlier: miss

    // Index wider than the sets present, ways beyond the maximum
    plan_drain();
    plan_cfg(REG_SPARE, 5'h1F);
    plan_geometry(5'd0, 5'd15, 5'd31);
    plan_req(KIND_READ,  48'h3FF);             // top set
    plan_req(KIND_WRITE, 48'h3FF);
    plan_req(KIND_READ,  48'h400);             // set 0, tag 1

    // Huge offset, no set index (bit 4 of the write is dropped), zero ways.
    // Tag 1 from the previous geometry is still valid: no flush, so a hit.
    plan_geometry(5'd31, 5'h10, 5'd0);
    plan_req(KIND_READ,  48'h8000_0000);
    plan_req(KIND_WRITE, 48'h7FFF_FFFF);
    plan_req(KIND_READ,  48'hFFFF_FFFF_FFFF);

    // Stale FIFO pointer: fill three ways of set 0, then drop to two ways
    plan_geometry(5'd4, 5'd2, 5'd4);
    plan_req(KIND_READ,  48'h4000);
    plan_req(KIND_READ,  48'h4040);
    plan_req(KIND_WRITE, 48'h4080);
    plan_geometry(5'd4, 5'd2, 5'd2);
    plan_req(KIND_READ,  48'h40C0);            // pointer at 3 >= 2: victim is way 0
    plan_req(KIND_READ,  48'h4040);            // way 1 survives
    plan_req(KIND_WRITE, 48'h4080);            // way 2 no longer looked at

    // Offset 16 with the largest usable index, at full associativity
    plan_geometry(5'd16, 5'd10, 5'd16);
    plan_req(KIND_WRITE, 48'hFFFF_FFFF_FFFF);
    plan_req(KIND_READ,  48'hFFFF_FFFF_FFFF);
    plan_req(KIND_READ,  48'h0);

    // Random phases: mostly tags drawn from a small pool over a few sets so
    // that hits, refills and FIFO wrap-around all occur; the rest is noise.
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin off_w = 5'd0;  ib_w = 5'd0;  ways_w = 5'd16; end  // fully assoc.
        1: begin off_w = 5'd16; ib_w = 5'd10; ways_w = 5'd1;  end  // direct-mapped
        2: begin off_w = 5'd0;  ib_w = 5'd10; ways_w = 5'd16; end
        3: begin off_w = 5'd31; ib_w = 5'd31; ways_w = 5'd31; end
        default: begin
          off_w  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(0, 16));
          ib_w   = 5'($urandom_range(0, 31));
          ways_w = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(1, 16));
        end
      endcase
      plan_geometry(off_w, ib_w, ways_w);
      nsets = $urandom_range(1, 4);
      ntags = plan_ways + $urandom_range(0, plan_ways + 2);
      for (int i = 0; i < nsets; i++) set_pool[i] = rand48() & ((48'd1 << plan_ib) - 48'd1);
      for (int i = 0; i < ntags; i++) tag_pool[i] = rand48();
      for (int j = 0; j < PHASE_REQS; j++) begin
        if (j % 15 == 0) quiet_run = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) begin
          addr = rand48();
        end else begin
          addr = (tag_pool[$urandom_range(0, ntags - 1)] << (plan_off + plan_ib)) |
                 (set_pool[$urandom_range(0, nsets - 1)] << plan_off) |
                 (rand48() & ((48'd1 << plan_off) - 48'd1));
        end
        plan_req(1'($urandom_range(0, 1)), addr);
        // sender holds off mid-phase until the block has caught up
        if (j == PHASE_REQS / 2 && p % 3 == 1) plan_drain();
      end
    end
    plan_drain();

    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // the final drain step leaves the plan only once every result is in
    while (access_plan_q.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (outcome_errors == 0 && outcome_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (outcome_q.size() != 0) $display("%0d results never arrived", outcome_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
